>>> hdl/prb_pkg.sv
// ----------------------------------------------------------------------------
// prb_pkg: shared types and constants for the packet reorder buffer
// Command codes, result status codes and the request/result records passed
// between the classifier, the command queue and the delivery engine.
// ----------------------------------------------------------------------------
package prb_pkg;

  // Receive window size in slots. The slot index is the low bits of the
  // sequence number, so the window must be a power of two.
  localparam int WINDOW = 64;
  localparam int SLOT_W = $clog2(WINDOW);

  // Command queue depth between classifier and delivery engine
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);

  localparam int TIME_W = 64;
  localparam int SEQ_W  = 16;
  localparam int PN_W   = 16;
  localparam int LEN_W  = 11;
  localparam int TAG_W  = 16;
  localparam int OVH_W  = 8;
  localparam int ST_W   = 3;

  // Result status codes
  localparam logic [ST_W-1:0] ST_DELIVERED = 3'd0;
  localparam logic [ST_W-1:0] ST_WAITING   = 3'd1;
  localparam logic [ST_W-1:0] ST_SHORT     = 3'd2;
  localparam logic [ST_W-1:0] ST_STALE     = 3'd3;
  localparam logic [ST_W-1:0] ST_OLD       = 3'd4;
  localparam logic [ST_W-1:0] ST_BEYOND    = 3'd5;

  // What the classifier decided for one request
  typedef enum logic [2:0] {
    CMD_SHORT,   // payload empty: drop
    CMD_STALE,   // timestamp older than newest: drop, no ack
    CMD_OLD,     // sequence behind expected: ack only
    CMD_BEYOND,  // sequence past the window: ack only
    CMD_WAIT,    // store out of order, wait for the gap
    CMD_DRAIN    // expected sequence: deliver it and the run behind it
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [PN_W-1:0]    pkt_num;
    logic [SLOT_W-1:0]  slot;
    logic [TAG_W-1:0]   tag;
    logic [LEN_W-1:0]   len;
  } cmd_t;

  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic              ack_req;
    logic [PN_W-1:0]   ack_pkt_num;
    logic              deliver;
    logic [SEQ_W-1:0]  seq;
    logic [TAG_W-1:0]  tag;
    logic [LEN_W-1:0]  len;
    logic              last;
  } result_t;

endpackage

>>> hdl/prb_front.sv
// ----------------------------------------------------------------------------
// prb_front: request capture and classification
// Registers an accepted request, then checks length, timestamp and sequence
// window, and pushes one command into the queue.
// ----------------------------------------------------------------------------
module prb_front import prb_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  logic [TIME_W-1:0]  send_time,
  input  logic [SEQ_W-1:0]   seq_num,
  input  logic [PN_W-1:0]    pkt_num,
  input  logic [LEN_W-1:0]   pkt_len,
  input  logic [TAG_W-1:0]   buf_tag,
  input  logic [OVH_W-1:0]   header_overhead,
  input  logic [SEQ_W-1:0]   expected_seq,
  input  logic               q_full,
  output logic               push,
  output cmd_t               push_cmd,
  output logic               busy
);

  logic              hold_r;
  logic [TIME_W-1:0] time_r;
  logic [SEQ_W-1:0]  seq_r;
  logic [PN_W-1:0]   pn_r;
  logic [LEN_W-1:0]  len_r;
  logic [TAG_W-1:0]  tag_r;
  logic [TIME_W-1:0] newest_r, newest_nxt;

  logic [LEN_W-1:0]  ovh_ext;
  logic [SEQ_W-1:0]  seq_gap;
  logic              too_short, stale;

  assign ovh_ext   = {{(LEN_W-OVH_W){1'b0}}, header_overhead};
  assign too_short = (len_r <= ovh_ext);
  assign stale     = (time_r < newest_r);
  assign seq_gap   = seq_r - expected_seq;

  assign push = hold_r && !q_full;
  assign busy = hold_r;

  always_comb begin
    push_cmd.pkt_num = pn_r;
    push_cmd.slot    = seq_r[SLOT_W-1:0];
    push_cmd.tag     = tag_r;
    push_cmd.len     = len_r - ovh_ext;
    newest_nxt       = newest_r;
    priority if (too_short) begin
      push_cmd.kind = CMD_SHORT;
    end else if (stale) begin
      push_cmd.kind = CMD_STALE;
    end else begin
      newest_nxt = time_r;
      priority if (seq_gap[SEQ_W-1]) begin
        push_cmd.kind = CMD_OLD;
      end else if (seq_gap >= SEQ_W'(WINDOW)) begin
        push_cmd.kind = CMD_BEYOND;
      end else if (seq_gap != '0) begin
        push_cmd.kind = CMD_WAIT;
      end else begin
        push_cmd.kind = CMD_DRAIN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r   <= 1'b0;
      newest_r <= '0;
    end else begin
      if (accept) begin
        hold_r <= 1'b1;
      end else if (push) begin
        hold_r <= 1'b0;
      end
      if (push) begin
        newest_r <= newest_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      time_r <= send_time;
      seq_r  <= seq_num;
      pn_r   <= pkt_num;
      len_r  <= pkt_len;
      tag_r  <= buf_tag;
    end
  end

endmodule

>>> hdl/prb_queue.sv
// ----------------------------------------------------------------------------
// prb_queue: command queue between classifier and delivery engine
// Small register FIFO of classified commands.
// ----------------------------------------------------------------------------
module prb_queue import prb_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic valid,
  output cmd_t head
);

  cmd_t              entry_r [QDEPTH];
  logic [QPTR_W-1:0] wptr_r, rptr_r;
  logic [QPTR_W:0]   count_r;

  assign valid = (count_r != '0);
  assign full  = (count_r == (QPTR_W+1)'(QDEPTH));
  assign head  = entry_r[rptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wptr_r <= (wptr_r == QPTR_W'(QDEPTH-1)) ? '0 : wptr_r + 1'b1;
      end
      if (pop) begin
        rptr_r <= (rptr_r == QPTR_W'(QDEPTH-1)) ? '0 : rptr_r + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wptr_r] <= push_cmd;
    end
  end

endmodule

>>> hdl/prb_back.sv
// ----------------------------------------------------------------------------
// prb_back: slot store and in-order delivery engine
// Executes queued commands, holds the slot memory and occupancy bits,
// tracks the expected sequence and drains contiguous runs, one delivery per cycle.
// ----------------------------------------------------------------------------
module prb_back import prb_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  cmd_t              q_head,
  output logic              pop,
  output logic [SEQ_W-1:0]  expected_seq,
  output logic              busy,
  output logic              res_valid,
  output result_t           res
);

  typedef enum logic [1:0] {
    B_IDLE  = 2'b01,
    B_DRAIN = 2'b10
  } back_state_t;

  back_state_t       state_r, state_nxt;
  logic [SEQ_W-1:0]  exp_r, exp_nxt;
  logic [WINDOW-1:0] full_r, full_nxt;

  logic [TAG_W-1:0]  mem_tag [WINDOW];
  logic [LEN_W-1:0]  mem_len [WINDOW];
  logic [TAG_W-1:0]  rd_tag_r;
  logic [LEN_W-1:0]  rd_len_r;
  logic [SLOT_W-1:0] exp_slot, next_slot;
  logic              wr_en;

  logic              res_valid_r, res_valid_nxt;
  result_t           res_r, res_nxt;

  assign exp_slot     = exp_r[SLOT_W-1:0];
  assign next_slot    = exp_slot + 1'b1;
  assign expected_seq = exp_r;
  assign busy         = (state_r == B_DRAIN);
  assign res_valid    = res_valid_r;
  assign res          = res_r;

  always_comb begin
    state_nxt     = state_r;
    exp_nxt       = exp_r;
    full_nxt      = full_r;
    pop           = 1'b0;
    wr_en         = 1'b0;
    res_valid_nxt = 1'b0;
    res_nxt       = '0;
    unique case (state_r)
      B_IDLE: begin
        if (q_valid) begin
          pop           = 1'b1;
          res_valid_nxt = 1'b1;
          res_nxt.last  = 1'b1;
          unique case (q_head.kind)
            CMD_SHORT: res_nxt.status = ST_SHORT;
            CMD_STALE: res_nxt.status = ST_STALE;
            CMD_OLD: begin
              res_nxt.status      = ST_OLD;
              res_nxt.ack_req     = 1'b1;
              res_nxt.ack_pkt_num = q_head.pkt_num;
            end
            CMD_BEYOND: begin
              res_nxt.status      = ST_BEYOND;
              res_nxt.ack_req     = 1'b1;
              res_nxt.ack_pkt_num = q_head.pkt_num;
            end
            CMD_WAIT: begin
              res_nxt.status         = ST_WAITING;
              res_nxt.ack_req        = 1'b1;
              res_nxt.ack_pkt_num    = q_head.pkt_num;
              wr_en                  = 1'b1;
              full_nxt[q_head.slot]  = 1'b1;
            end
            CMD_DRAIN: begin
              // head of run comes straight from the command, no slot write
              res_nxt.status      = ST_DELIVERED;
              res_nxt.ack_req     = 1'b1;
              res_nxt.ack_pkt_num = q_head.pkt_num;
              res_nxt.deliver     = 1'b1;
              res_nxt.seq         = exp_r;
              res_nxt.tag         = q_head.tag;
              res_nxt.len         = q_head.len;
              full_nxt[exp_slot]  = 1'b0;
              exp_nxt             = exp_r + 1'b1;
              if (full_r[next_slot]) begin
                res_nxt.last = 1'b0;
                state_nxt    = B_DRAIN;
              end
            end
            default: res_nxt.status = ST_SHORT;
          endcase
        end
      end
      B_DRAIN: begin
        // slot exp_slot is known full; its data was read last cycle
        res_valid_nxt      = 1'b1;
        res_nxt.status     = ST_DELIVERED;
        res_nxt.deliver    = 1'b1;
        res_nxt.seq        = exp_r;
        res_nxt.tag        = rd_tag_r;
        res_nxt.len        = rd_len_r;
        full_nxt[exp_slot] = 1'b0;
        exp_nxt            = exp_r + 1'b1;
        if (!full_r[next_slot]) begin
          res_nxt.last = 1'b1;
          state_nxt    = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      exp_r       <= '0;
      full_r      <= '0;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      exp_r       <= exp_nxt;
      full_r      <= full_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  // slot memory: one write port, one registered read port (next slot)
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_tag[q_head.slot] <= q_head.tag;
      mem_len[q_head.slot] <= q_head.len;
    end
    rd_tag_r <= mem_tag[next_slot];
    rd_len_r <= mem_len[next_slot];
  end

endmodule

>>> hdl/packet_reorder_buffer.sv
// ----------------------------------------------------------------------------
// packet_reorder_buffer: in-order delivery of received data packets
// Drops short and stale packets, acknowledges the rest, stores out-of-order
// packets in a 64-slot window and hands contiguous runs up in order.
// ----------------------------------------------------------------------------
//
//  channel   handshake                  payload
//  --------  -------------------------  ------------------------------------
//  request   start / busy               in_send_time .. in_buf_tag
//  result    out_valid (strobe)         out_status .. out_last
//  config    psel/penable/pwrite/pready paddr, pwdata, prdata
//
// Timing:
//  - A taken request is registered and classified in the front end, queued,
//    then executed by the delivery engine, which registers the result.
//  - A run of N deliveries shows N results back to back (one slot memory
//    read per cycle); busy drops in the cycle the last result is on the
//    ports, so the next request can be taken in that cycle.
//  - Reset (rst_n low, synchronous) clears timestamp, expected sequence and
//    slot occupancy; slot contents need no clearing.
//  - The receiver cannot stall: each result is valid for one cycle only.
//
module packet_reorder_buffer import prb_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  // request channel
  input  logic              start,
  output logic              busy,
  input  logic [TIME_W-1:0] in_send_time,
  input  logic [SEQ_W-1:0]  in_seq_num,
  input  logic [PN_W-1:0]   in_pkt_num,
  input  logic [LEN_W-1:0]  in_pkt_len,
  input  logic [TAG_W-1:0]  in_buf_tag,
  // result channel
  output logic              out_valid,
  output logic [ST_W-1:0]   out_status,
  output logic              out_ack_req,
  output logic [PN_W-1:0]   out_ack_pkt_num,
  output logic              out_deliver,
  output logic [SEQ_W-1:0]  out_seq,
  output logic [TAG_W-1:0]  out_tag,
  output logic [LEN_W-1:0]  out_len,
  output logic              out_last,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic             accept;
  logic [OVH_W-1:0] ovh_r;
  logic             front_busy, back_busy;
  logic             push, pop, q_full, q_valid;
  cmd_t             push_cmd, q_head;
  logic [SEQ_W-1:0] expected_seq;
  logic             res_valid;
  result_t          res;

  // --- configuration: header_overhead at word 0, other words read as zero
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {{(32-OVH_W){1'b0}}, ovh_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovh_r <= '0;
    end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
      ovh_r <= pwdata[OVH_W-1:0];
    end
  end

  // --- one request in flight at a time: classification depends on the
  // expected sequence left behind by the previous drain
  assign busy   = front_busy || q_valid || back_busy;
  assign accept = start && !busy;

  prb_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .accept          (accept),
    .send_time       (in_send_time),
    .seq_num         (in_seq_num),
    .pkt_num         (in_pkt_num),
    .pkt_len         (in_pkt_len),
    .buf_tag         (in_buf_tag),
    .header_overhead (ovh_r),
    .expected_seq    (expected_seq),
    .q_full          (q_full),
    .push            (push),
    .push_cmd        (push_cmd),
    .busy            (front_busy)
  );

  prb_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .valid    (q_valid),
    .head     (q_head)
  );

  prb_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (q_valid),
    .q_head       (q_head),
    .pop          (pop),
    .expected_seq (expected_seq),
    .busy         (back_busy),
    .res_valid    (res_valid),
    .res          (res)
  );

  // --- result ports (registered inside the delivery engine)
  assign out_valid       = res_valid;
  assign out_status      = res.status;
  assign out_ack_req     = res.ack_req;
  assign out_ack_pkt_num = res.ack_pkt_num;
  assign out_deliver     = res.deliver;
  assign out_seq         = res.seq;
  assign out_tag         = res.tag;
  assign out_len         = res.len;
  assign out_last        = res.last;

endmodule

>>> hdl/prb_checker.sv
// ----------------------------------------------------------------------------
// prb_checker: port-level checks for the packet reorder buffer
// Watches the request and result ports over time; bound to the top level.
// ----------------------------------------------------------------------------
module prb_checker import prb_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             start,
  input logic             busy,
  input logic             out_valid,
  input logic [ST_W-1:0]  out_status,
  input logic             out_ack_req,
  input logic [PN_W-1:0]  out_ack_pkt_num,
  input logic             out_deliver,
  input logic [SEQ_W-1:0] out_seq,
  input logic             out_last
);

  // a taken request keeps the block busy on the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy low right after a request was taken");

  // a delivery run has no gaps
  a_run_gapless: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |=> out_valid && out_deliver)
    else $error("delivery run broke before its last result");

  // consecutive deliveries carry consecutive sequence numbers
  a_run_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_deliver && !out_last |=> out_seq == $past(out_seq) + 1'b1)
    else $error("delivery run out of sequence order");

  // only a delivery may leave more results to follow
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (!out_deliver || out_status != ST_DELIVERED) |-> out_last)
    else $error("non-delivery result not marked last");

  // no acknowledgement number without an acknowledgement request
  a_ack_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ack_req |-> out_ack_pkt_num == '0)
    else $error("ack packet number set without ack request");

endmodule

bind packet_reorder_buffer prb_checker u_prb_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_status      (out_status),
  .out_ack_req     (out_ack_req),
  .out_ack_pkt_num (out_ack_pkt_num),
  .out_deliver     (out_deliver),
  .out_seq         (out_seq),
  .out_last        (out_last)
);
